### design/llmq_pkg.sv
// ----------------------------------------------------------------------------
// llmq_pkg
// shared constants, operation codes and controller/datapath link types
// for the linked list message queue
// ----------------------------------------------------------------------------
package llmq_pkg;

  localparam int SLOTS   = 64;
  localparam int QUEUES  = 4;
  localparam int SLOT_W  = 6;
  localparam int QUEUE_W = 2;
  localparam int OP_W    = 2;
  localparam int LINK_W  = SLOT_W + 1;

  localparam int IN_W    = 16;
  localparam int OUT_W   = 8;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNLINK = 2'd3;

  typedef struct packed {
    logic accept;
    logic exec;
    logic wr2;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need2;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic              got_valid;
    logic [SLOT_W-1:0] got_slot;
    logic              now_empty;
  } result_t;

endpackage

### design/linked_list_message_queue.sv
// ----------------------------------------------------------------------------
// linked_list_message_queue
// several singly linked queues of message slots in one next-link memory
// ----------------------------------------------------------------------------
// Each item names a queue and an operation (append at tail, remove head,
// push at head, unlink a slot given its predecessor) and gives one result
// item. An item starts with the registered read of the link memory, then
// makes one link write per cycle through its single write port; an append
// to a non-empty queue and an unlink below the head need a second write. A
// new item is taken while the previous result still waits at the output.
// Link memory entries are undefined until a slot is appended or pushed.
// ----------------------------------------------------------------------------
module linked_list_message_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // op[1:0], queue_id[3:2], slot[9:4], prev_slot[15:10]
  input  logic [llmq_pkg::IN_W-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // got_slot[5:0], now_empty[6], zero[7]
  output logic [llmq_pkg::OUT_W-1:0] m_axis_tdata,
  // got_valid[0]
  output logic                      m_axis_tuser
);

  import llmq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    res;

  llmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  llmq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {1'b0, res.now_empty, res.got_slot};
  assign m_axis_tuser = res.got_valid;

endmodule

### design/llmq_ram.sv
// ----------------------------------------------------------------------------
// llmq_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module llmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### design/llmq_ctrl.sv
// ----------------------------------------------------------------------------
// llmq_ctrl
// sequencer: accept, execute with link read data, optional second link
// write, hold until the output register is free
// ----------------------------------------------------------------------------
module llmq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  llmq_pkg::dp_status_t status_i,
  output llmq_pkg::ctrl_cmd_t  cmd_o
);

  import llmq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WR2  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.need2) begin
          state_d = ST_WR2;
        end else if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_WR2: begin
        cmd_o.wr2 = 1'b1;
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/llmq_dp.sv
// ----------------------------------------------------------------------------
// llmq_dp
// queue head, tail and empty registers, next-link ram and output register
// ----------------------------------------------------------------------------
module llmq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [llmq_pkg::IN_W-1:0]     in_data_i,
  input  llmq_pkg::ctrl_cmd_t           cmd_i,
  output llmq_pkg::dp_status_t          status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output llmq_pkg::result_t             out_res_o
);

  import llmq_pkg::*;

  logic [OP_W-1:0]    in_op;
  logic [QUEUE_W-1:0] in_qid;
  logic [SLOT_W-1:0]  in_slot;
  logic [SLOT_W-1:0]  in_prev;

  logic [OP_W-1:0]    op_q;
  logic [QUEUE_W-1:0] qid_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [SLOT_W-1:0]  prev_q;

  logic [SLOT_W-1:0]  head_q [QUEUES];
  logic [SLOT_W-1:0]  tail_q [QUEUES];
  logic [QUEUES-1:0]  empty_q;

  logic [LINK_W-1:0]  link_rd;
  logic [LINK_W-1:0]  link_m1;
  logic [SLOT_W-1:0]  head_cur, tail_cur;
  logic               empty_cur;

  logic               wa_en;
  logic [SLOT_W-1:0]  wa_addr;
  logic [LINK_W-1:0]  wa_data;
  logic               w2_need;
  logic [SLOT_W-1:0]  w2_addr_d, w2_addr_q;
  logic [LINK_W-1:0]  w2_data_d, w2_data_q;
  logic [SLOT_W-1:0]  head_nx, tail_nx;
  logic               empty_nx;
  result_t            res_d, res_q;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [LINK_W-1:0]  ram_wdata;
  logic [SLOT_W-1:0]  ram_raddr;

  logic               out_valid_q;
  result_t            out_res_q;

  assign in_op   = in_data_i[1:0];
  assign in_qid  = in_data_i[3:2];
  assign in_slot = in_data_i[9:4];
  assign in_prev = in_data_i[15:10];

  assign head_cur  = head_q[qid_q];
  assign tail_cur  = tail_q[qid_q];
  assign empty_cur = empty_q[qid_q];
  assign link_m1   = link_rd - LINK_W'(1);

  always_comb begin
    wa_en     = 1'b0;
    wa_addr   = slot_q;
    wa_data   = '0;
    w2_need   = 1'b0;
    w2_addr_d = slot_q;
    w2_data_d = '0;
    head_nx   = head_cur;
    tail_nx   = tail_cur;
    empty_nx  = empty_cur;
    res_d     = '0;
    unique case (op_q)
      OP_APPEND: begin
        wa_en   = 1'b1;
        tail_nx = slot_q;
        if (empty_cur) begin
          head_nx  = slot_q;
          empty_nx = 1'b0;
        end else begin
          w2_need   = 1'b1;
          w2_addr_d = tail_cur;
          w2_data_d = LINK_W'(slot_q) + LINK_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!empty_cur) begin
          wa_en   = 1'b1;
          wa_addr = head_cur;
          if (link_rd == '0) begin
            empty_nx = 1'b1;
          end else begin
            head_nx = link_m1[SLOT_W-1:0];
          end
          res_d.got_valid = 1'b1;
          res_d.got_slot  = head_cur;
        end
      end
      OP_PUSH: begin
        wa_en   = 1'b1;
        head_nx = slot_q;
        if (empty_cur) begin
          tail_nx  = slot_q;
          empty_nx = 1'b0;
        end else begin
          wa_data = LINK_W'(head_cur) + LINK_W'(1);
        end
      end
      OP_UNLINK: begin
        if (!empty_cur) begin
          wa_en = 1'b1;
          if (slot_q == head_cur) begin
            if (link_rd == '0) begin
              empty_nx = 1'b1;
            end else begin
              head_nx = link_m1[SLOT_W-1:0];
            end
          end else begin
            wa_addr = prev_q;
            wa_data = link_rd;
            w2_need = 1'b1;
            if (slot_q == tail_cur) begin
              tail_nx = prev_q;
            end
          end
        end
      end
      default: ;
    endcase
    res_d.now_empty = empty_nx;
  end

  assign ram_we    = cmd_i.exec ? wa_en : cmd_i.wr2;
  assign ram_waddr = cmd_i.exec ? wa_addr : w2_addr_q;
  assign ram_wdata = cmd_i.exec ? wa_data : w2_data_q;
  assign ram_raddr = (in_op == OP_REMOVE) ? head_q[in_qid] : in_slot;

  llmq_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (ram_raddr),
    .rdata_o (link_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= in_op;
      qid_q  <= in_qid;
      slot_q <= in_slot;
      prev_q <= in_prev;
    end
    if (cmd_i.exec) begin
      head_q[qid_q] <= head_nx;
      tail_q[qid_q] <= tail_nx;
      w2_addr_q     <= w2_addr_d;
      w2_data_q     <= w2_data_d;
      res_q         <= res_d;
    end
    if (cmd_i.load_out) begin
      out_res_q <= cmd_i.exec ? res_d : res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q     <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        empty_q[qid_q] <= empty_nx;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.need2    = w2_need;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_res_o         = out_res_q;

endmodule

### tb/tb_linked_list_message_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linked_list_message_queue
// self-checking regression for the linked list message queue
// ----------------------------------------------------------------------------
// A table of directed operations walks the corner cases: remove and unlink on
// an empty queue, unlink of the head, of the tail and of a middle slot, a
// slot put in twice and a wrong predecessor. Random traffic follows, mostly
// well-formed operations on the slots that are really linked, with some noise
// mixed in. Every result item is checked against a model of the queues that
// runs alongside, under three patterns of stalls on both streams.
// ----------------------------------------------------------------------------
module tb_linked_list_message_queue;
  import llmq_pkg::*;

  localparam int ROWS         = 25;
  localparam int PHASE_ITEMS  = 660;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [QUEUE_W-1:0] qid;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  prev;
    logic               typed;
    result_t            res;
  } row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // op[1:0], queue_id[3:2], slot[9:4], prev_slot[15:10]
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // got_slot[5:0], now_empty[6], zero[7]
  logic [OUT_W-1:0]  m_axis_tdata;
  // got_valid[0]
  logic              m_axis_tuser;

  logic [SLOT_W-1:0] q_head [QUEUES];
  logic [SLOT_W-1:0] q_tail [QUEUES];
  bit                q_empty [QUEUES];
  logic [LINK_W-1:0] slot_link [SLOTS];
  bit                slot_known [SLOTS];
  logic [SLOT_W-1:0] queue_slots [$];
  result_t           awaited_results [$];
  row_t              directed_rows [ROWS];

  int send_idle   = 36;
  int recv_idle   = 68;
  int mismatches  = 0;
  int cycle_count = 0;

  always #6 clk_i = ~clk_i;

  linked_list_message_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic result_t apply_queue_op(logic [OP_W-1:0] op, logic [QUEUE_W-1:0] q,
                                             logic [SLOT_W-1:0] s, logic [SLOT_W-1:0] p);
    result_t           r;
    logic [LINK_W-1:0] n;
    logic [SLOT_W-1:0] h;
    r = '0;
    case (op)
      OP_APPEND: begin
        slot_link[s]  = '0;
        slot_known[s] = 1'b1;
        if (q_empty[q]) begin
          q_head[q]  = s;
          q_empty[q] = 1'b0;
        end else begin
          slot_link[q_tail[q]] = {1'b0, s} + LINK_W'(1);
        end
        q_tail[q] = s;
      end
      OP_REMOVE: begin
        if (!q_empty[q]) begin
          h            = q_head[q];
          n            = slot_link[h];
          slot_link[h] = '0;
          if (n == '0) q_empty[q] = 1'b1;
          else q_head[q] = SLOT_W'(n - LINK_W'(1));
          r.got_valid = 1'b1;
          r.got_slot  = h;
        end
      end
      OP_PUSH: begin
        slot_known[s] = 1'b1;
        if (q_empty[q]) begin
          slot_link[s] = '0;
          q_tail[q]    = s;
          q_empty[q]   = 1'b0;
        end else begin
          slot_link[s] = {1'b0, q_head[q]} + LINK_W'(1);
        end
        q_head[q] = s;
      end
      default: begin
        if (!q_empty[q]) begin
          n = slot_link[s];
          if (s == q_head[q]) begin
            if (n == '0) q_empty[q] = 1'b1;
            else q_head[q] = SLOT_W'(n - LINK_W'(1));
          end else begin
            slot_link[p] = n;
            if (s == q_tail[q]) q_tail[q] = p;
          end
          slot_link[s] = '0;
        end
      end
    endcase
    r.now_empty = q_empty[q];
    return r;
  endfunction

  // slots reached from the head, bounded against loops from misuse
  function automatic void walk_queue(logic [QUEUE_W-1:0] q);
    logic [SLOT_W-1:0] cur;
    queue_slots.delete();
    if (q_empty[q]) return;
    cur = q_head[q];
    repeat (SLOTS) begin
      queue_slots.push_back(cur);
      if (cur == q_tail[q] || slot_link[cur] == '0) break;
      cur = SLOT_W'(slot_link[cur] - LINK_W'(1));
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic pick_item(output logic [IN_W-1:0] d);
    logic [OP_W-1:0]    op;
    logic [QUEUE_W-1:0] q;
    logic [SLOT_W-1:0]  s;
    logic [SLOT_W-1:0]  p;
    bit                 slot_busy [SLOTS];
    int                 roll;
    int                 k;
    int                 tries;
    q    = QUEUE_W'($urandom);
    s    = SLOT_W'($urandom);
    p    = SLOT_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      op = OP_W'($urandom);
    end else if (roll < 55) begin
      op = (roll < 45) ? OP_APPEND : OP_PUSH;
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      for (int j = 0; j < QUEUES; j++) begin
        walk_queue(QUEUE_W'(j));
        foreach (queue_slots[i]) slot_busy[queue_slots[i]] = 1'b1;
      end
      tries = 0;
      while (slot_busy[s] && tries < 16) begin
        s = SLOT_W'($urandom);
        tries++;
      end
      if (slot_busy[s]) op = OP_REMOVE;
    end else if (roll < 78) begin
      op = OP_REMOVE;
    end else begin
      op = OP_UNLINK;
      walk_queue(q);
      if (queue_slots.size() != 0) begin
        k = $urandom_range(0, queue_slots.size() - 1);
        s = queue_slots[k];
        if (k > 0) p = queue_slots[k - 1];
      end
    end
    // a link that was never written must not be read
    if (op == OP_UNLINK && !slot_known[s]) op = OP_APPEND;
    d = {p, s, q, op};
  endtask

  task automatic send_item(logic [IN_W-1:0] d, logic typed, result_t typed_res);
    result_t r;
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(negedge clk_i); while (s_axis_tready !== 1'b1);
    @(posedge clk_i);
    r = apply_queue_op(d[1:0], d[3:2], d[9:4], d[15:10]);
    awaited_results.push_back(typed ? typed_res : r);
  endtask

  task automatic hold_off();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count   <= cycle_count + 1;
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(negedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result item with none awaited", m_axis_tdata, 0);
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser !== want.got_valid)
          report_mismatch("got_valid", m_axis_tuser, want.got_valid);
        if (m_axis_tdata[SLOT_W-1:0] !== want.got_slot)
          report_mismatch("got_slot", m_axis_tdata[SLOT_W-1:0], want.got_slot);
        if (m_axis_tdata[SLOT_W] !== want.now_empty)
          report_mismatch("now_empty", m_axis_tdata[SLOT_W], want.now_empty);
        if (m_axis_tdata[OUT_W-1] !== 1'b0)
          report_mismatch("pad bit", m_axis_tdata[OUT_W-1], 0);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("linked_list_message_queue regression: fail");
    $finish;
  end

  initial begin
    logic [IN_W-1:0] d;
    foreach (q_empty[i]) q_empty[i] = 1'b1;
    foreach (slot_link[i]) slot_link[i] = '0;
    foreach (slot_known[i]) slot_known[i] = 1'b0;
    directed_rows = '{
      '{OP_REMOVE, 2'd0, 6'd0,  6'd0,  1'b1, '{1'b0, 6'd0, 1'b1}},
      '{OP_APPEND, 2'd0, 6'd63, 6'd0,  1'b1, '{1'b0, 6'd0, 1'b0}},
      '{OP_APPEND, 2'd0, 6'd0,  6'd63, 1'b0, '0},
      '{OP_PUSH,   2'd0, 6'd21, 6'd0,  1'b0, '0},
      '{OP_REMOVE, 2'd0, 6'd0,  6'd0,  1'b0, '0},
      '{OP_REMOVE, 2'd0, 6'd0,  6'd0,  1'b0, '0},
      '{OP_REMOVE, 2'd0, 6'd0,  6'd0,  1'b0, '0},
      '{OP_REMOVE, 2'd0, 6'd63, 6'd63, 1'b1, '{1'b0, 6'd0, 1'b1}},
      '{OP_UNLINK, 2'd0, 6'd63, 6'd0,  1'b1, '{1'b0, 6'd0, 1'b1}},
      '{OP_PUSH,   2'd3, 6'd42, 6'd63, 1'b1, '{1'b0, 6'd0, 1'b0}},
      '{OP_APPEND, 2'd3, 6'd63, 6'd0,  1'b0, '0},
      '{OP_APPEND, 2'd3, 6'd0,  6'd0,  1'b0, '0},
      '{OP_APPEND, 2'd3, 6'd21, 6'd63, 1'b0, '0},
      '{OP_UNLINK, 2'd3, 6'd63, 6'd42, 1'b0, '0},
      '{OP_UNLINK, 2'd3, 6'd21, 6'd0,  1'b0, '0},
      '{OP_APPEND, 2'd3, 6'd63, 6'd0,  1'b0, '0},
      '{OP_UNLINK, 2'd3, 6'd42, 6'd0,  1'b0, '0},
      '{OP_REMOVE, 2'd3, 6'd0,  6'd0,  1'b0, '0},
      '{OP_UNLINK, 2'd3, 6'd63, 6'd63, 1'b0, '0},
      '{OP_APPEND, 2'd2, 6'd7,  6'd0,  1'b0, '0},
      '{OP_APPEND, 2'd2, 6'd7,  6'd0,  1'b0, '0},
      '{OP_APPEND, 2'd1, 6'd42, 6'd0,  1'b0, '0},
      '{OP_APPEND, 2'd1, 6'd21, 6'd0,  1'b0, '0},
      '{OP_UNLINK, 2'd1, 6'd21, 6'd63, 1'b0, '0},
      '{OP_REMOVE, 2'd2, 6'd0,  6'd0,  1'b0, '0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item({directed_rows[i].prev, directed_rows[i].slot, directed_rows[i].qid,
                 directed_rows[i].op}, directed_rows[i].typed, directed_rows[i].res);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 36;
          recv_idle = 68;
        end
        1: begin
          send_idle = 68;
          recv_idle = 36;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      hold_off();
      repeat (PHASE_ITEMS) begin
        pick_item(d);
        send_item(d, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("linked_list_message_queue regression: pass");
    else
      $display("linked_list_message_queue regression: fail");
    $finish;
  end

endmodule
